>>> rtl/core/lfr_pkg.sv
package lfr_pkg;

    // Default geometry of the frame store.
    localparam int ROWS_DEFAULT          = 64;
    localparam int BYTES_PER_ROW_DEFAULT = 16;

    // Item kinds carried on the input tuser.
    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_WRITE_PIXEL = 2'd0;
    localparam cmd_t CMD_CLEAR       = 2'd1;
    localparam cmd_t CMD_START       = 2'd2;
    localparam cmd_t CMD_TICK        = 2'd3;

    // Display command bytes sent ahead of each row.
    localparam logic [7:0] ROW_CMD_BASE  = 8'h80;
    localparam logic [7:0] HALF_CMD_UPPER = 8'h80;
    localparam logic [7:0] HALF_CMD_LOWER = 8'h88;

    // Positions inside a row: two command bytes, then data bytes.
    localparam logic [4:0] POS_ROW_CMD  = 5'd0;
    localparam logic [4:0] POS_HALF_CMD = 5'd1;
    localparam logic [4:0] POS_DATA0    = 5'd2;

endpackage

>>> rtl/core/lcd_framebuffer_refresh.sv
// A tick that emits a byte goes through the second stage, then the output register, to m_tdata.
// Throughput: one item per cycle for pixel writes, starts and ticks; a stalled output
// holds back input only when a second byte is ready behind it.
// A clear walks the frame store one byte per cycle, ROWS * 2**ceil(log2(BYTES_PER_ROW))
// bytes (1024 by default), with s_tready low. Reset runs the same pass after aresetn rises.
// aresetn is synchronous, active low; it idles the refresh sequencer and empties the output.
module lcd_framebuffer_refresh #(
    parameter int ROWS          = lfr_pkg::ROWS_DEFAULT,
    parameter int BYTES_PER_ROW = lfr_pkg::BYTES_PER_ROW_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // x [6:0], y [12:7], pixel_value [13], zero [15:14]
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic [0:0]  m_tuser,   // is_command [0]
    output logic        m_tlast
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    // Frame store, one byte per entry, row-major with a power-of-two stride.
    logic [7:0] mem [DEPTH];

    // Input item fields.
    lfr_pkg::cmd_t cmd;
    logic [6:0]    in_x;
    logic [5:0]    in_y;
    logic          in_pixel_value;

    // Control registers.
    logic          clear_busy_reg, clear_busy_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          active_reg, active_next;
    logic [5:0]    row_reg, row_next;
    logic [4:0]    pos_reg, pos_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          m_valid_reg, m_valid_next;

    // Second stage payload.
    logic          s1_write_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [7:0]    s1_mask_reg;
    logic          s1_value_reg;
    logic          s1_is_cmd_reg;
    logic [7:0]    s1_cmd_byte_reg;
    logic          s1_last_reg;
    logic          s1_fwd_reg;
    logic [7:0]    s1_fwd_data_reg;
    logic [7:0]    rd_data_reg;

    // Output register payload.
    logic [7:0]    m_data_reg;
    logic          m_is_cmd_reg;
    logic          m_last_reg;

    logic          accept;
    logic          out_free;
    logic          s1_stall;
    logic          pix_in_range;
    logic [AW-1:0] pix_addr;
    logic [7:0]    pix_mask;
    logic [4:0]    data_idx;
    logic [AW-1:0] data_addr;
    logic [AW-1:0] rd_addr;
    logic          emit_now;
    logic          row_done;
    logic          frame_done;
    logic          cur_is_cmd;
    logic [7:0]    cur_cmd_byte;
    logic          s1_wr;
    logic [7:0]    s1_base;
    logic [7:0]    s1_wr_data;
    logic          fwd_hit;

    assign cmd            = s_tuser;
    assign in_x           = s_tdata[6:0];
    assign in_y           = s_tdata[12:7];
    assign in_pixel_value = s_tdata[13];

    // Handshake: the input waits during a clear pass or behind a blocked byte.
    assign out_free = !m_valid_reg || m_tready;
    assign s1_stall = s1_valid_reg && !s1_write_reg && !out_free;
    assign s_tready = !clear_busy_reg && !s1_stall;
    assign accept   = s_tvalid && s_tready;

    // Pixel address and bit; the leftmost pixel sits in bit 7.
    assign pix_in_range = ({1'b0, in_y} < 7'(ROWS))
                       && ({1'b0, in_x[6:3]} < 5'(BYTES_PER_ROW));
    assign pix_addr     = {in_y[RW-1:0], in_x[CW+2:3]};
    assign pix_mask     = 8'h80 >> in_x[2:0];

    // Refresh sequencer outputs for the current position.
    assign data_idx     = pos_reg - lfr_pkg::POS_DATA0;
    assign data_addr    = {row_reg[RW-1:0], data_idx[CW-1:0]};
    assign emit_now     = (cmd == lfr_pkg::CMD_TICK) && active_reg;
    assign row_done     = pos_reg >= 5'(BYTES_PER_ROW + 1);
    assign frame_done   = row_done && (row_reg == 6'(ROWS - 1));
    assign cur_is_cmd   = pos_reg < lfr_pkg::POS_DATA0;
    assign cur_cmd_byte = (pos_reg == lfr_pkg::POS_ROW_CMD)
                        ? (lfr_pkg::ROW_CMD_BASE | {3'b000, row_reg[4:0]})
                        : (row_reg[5] ? lfr_pkg::HALF_CMD_LOWER : lfr_pkg::HALF_CMD_UPPER);

    assign rd_addr = (cmd == lfr_pkg::CMD_WRITE_PIXEL) ? pix_addr : data_addr;

    // Read-modify-write in the second stage, with the previous write forwarded.
    assign s1_wr      = s1_valid_reg && s1_write_reg;
    assign s1_base    = s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg;
    assign s1_wr_data = s1_value_reg ? (s1_base | s1_mask_reg) : (s1_base & ~s1_mask_reg);
    assign fwd_hit    = s1_wr && (s1_addr_reg == rd_addr);

    // Clear pass and refresh sequencer.
    always_comb begin
        clear_busy_next = clear_busy_reg;
        sweep_next      = sweep_reg;
        active_next     = active_reg;
        row_next        = row_reg;
        pos_next        = pos_reg;
        if (clear_busy_reg) begin
            sweep_next = sweep_reg + 1'b1;
            if (sweep_reg == AW'(DEPTH - 1)) begin
                clear_busy_next = 1'b0;
            end
        end
        if (accept) begin
            unique case (cmd)
                lfr_pkg::CMD_CLEAR: begin
                    clear_busy_next = 1'b1;
                    sweep_next      = '0;
                end
                lfr_pkg::CMD_START: begin
                    active_next = 1'b1;
                    row_next    = '0;
                    pos_next    = '0;
                end
                lfr_pkg::CMD_TICK: begin
                    if (active_reg) begin
                        if (row_done) begin
                            pos_next = '0;
                            if (frame_done) begin
                                active_next = 1'b0;
                                row_next    = '0;
                            end else begin
                                row_next = row_reg + 1'b1;
                            end
                        end else begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Stage occupancy.
    always_comb begin
        if (accept) begin
            s1_valid_next = ((cmd == lfr_pkg::CMD_WRITE_PIXEL) && pix_in_range) || emit_now;
        end else begin
            s1_valid_next = s1_stall;
        end
        if (s1_valid_reg && !s1_write_reg && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            sweep_reg      <= '0;
            active_reg     <= 1'b0;
            row_reg        <= '0;
            pos_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            clear_busy_reg <= clear_busy_next;
            sweep_reg      <= sweep_next;
            active_reg     <= active_next;
            row_reg        <= row_next;
            pos_reg        <= pos_next;
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Frame store: one write port shared by the clear pass and pixel writes.
    always_ff @(posedge aclk) begin
        if (clear_busy_reg) begin
            mem[sweep_reg] <= 8'h00;
        end else if (s1_wr) begin
            mem[s1_addr_reg] <= s1_wr_data;
        end
        if (accept) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Second stage payload, loaded with each accepted item.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_write_reg    <= (cmd == lfr_pkg::CMD_WRITE_PIXEL);
            s1_addr_reg     <= pix_addr;
            s1_mask_reg     <= pix_mask;
            s1_value_reg    <= in_pixel_value;
            s1_is_cmd_reg   <= cur_is_cmd;
            s1_cmd_byte_reg <= cur_cmd_byte;
            s1_last_reg     <= frame_done;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= s1_wr_data;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (s1_valid_reg && !s1_write_reg && out_free) begin
            m_data_reg   <= s1_is_cmd_reg ? s1_cmd_byte_reg : s1_base;
            m_is_cmd_reg <= s1_is_cmd_reg;
            m_last_reg   <= s1_last_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_is_cmd_reg;
    assign m_tlast    = m_last_reg;

endmodule

>>> rtl/core/lfr_checker.sv
module lfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // A blocked output item keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("output item changed while stalled");

    // The frame ends on a data byte, never on a command byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser[0])
        else $error("last item of frame is a command byte");

    // Every command byte has its top bit set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[7])
        else $error("command byte without its top bit");

    // The store is being cleared right after reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("input ready during the clear pass after reset");

    // An accepted clear holds off the input in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == lfr_pkg::CMD_CLEAR) |=> !s_tready)
        else $error("input ready right after a clear");

endmodule

bind lcd_framebuffer_refresh lfr_checker u_lfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> bench/lcd_framebuffer_refresh_test.sv
`timescale 1ns / 100ps

module lcd_framebuffer_refresh_test;

    localparam int ROWS          = lfr_pkg::ROWS_DEFAULT;
    localparam int BPR           = lfr_pkg::BYTES_PER_ROW_DEFAULT;
    localparam int STORE_STRIDE  = 16;
    localparam int STORE_DEPTH   = 1024;
    localparam int FRAME_BYTES   = ROWS * (BPR + 2);
    localparam int RANDOM_ITEMS  = 150;
    localparam int N_DIRECTED    = 23;

    // One byte toward the display, as the result channel carries it.
    typedef struct packed {
        logic [7:0] data;
        logic       is_cmd;
        logic       last;
    } lcd_byte_t;

    // One directed item; the wanted byte is used only when typed is set.
    typedef struct packed {
        lfr_pkg::cmd_t cmd;
        logic [6:0]    x;
        logic [5:0]    y;
        logic          v;
        logic          typed;
        logic [7:0]    want_data;
        logic          want_cmd;
        logic          want_last;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // x [6:0], y [12:7], pixel_value [13], zero [15:14]
    logic [1:0]  s_tuser = '0;    // cmd [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // out_byte [7:0]
    logic [0:0]  m_tuser;         // is_command [0]
    logic        m_tlast;

    // Shadow copy of the frame store and the refresh sequencer.
    logic [7:0]  shadow_store [0:STORE_DEPTH-1];
    logic [5:0]  frame_row;
    logic [4:0]  frame_pos;
    bit          refresh_on;

    lcd_byte_t   pending_bytes [$];
    stim_row_t   directed [N_DIRECTED];

    int          errors = 0;
    int          bytes_checked = 0;
    int          frames_seen = 0;
    int          clears_sent = 0;
    int          items_done = 0;
    bit          calm = 1'b0;

    lcd_framebuffer_refresh u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Apply one item to the shadow state and work out the byte it emits, if any.
    task automatic apply_lcd_item(input lfr_pkg::cmd_t cmd, input logic [6:0] x,
                                  input logic [5:0] y, input logic v,
                                  output bit emitted, output lcd_byte_t b);
        int addr;
        logic [2:0] bit_idx;
        emitted = 1'b0;
        b = '0;
        unique case (cmd)
            lfr_pkg::CMD_WRITE_PIXEL: begin
                if (int'(y) < ROWS && int'(x[6:3]) < BPR) begin
                    addr = (int'(y) * STORE_STRIDE + int'(x[6:3])) % STORE_DEPTH;
                    bit_idx = 3'd7 - x[2:0];
                    shadow_store[addr][bit_idx] = v;
                end
            end
            lfr_pkg::CMD_CLEAR: begin
                for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = 8'h00;
            end
            lfr_pkg::CMD_START: begin
                refresh_on = 1'b1;
                frame_row = '0;
                frame_pos = lfr_pkg::POS_ROW_CMD;
            end
            default: begin
                if (refresh_on) begin
                    emitted = 1'b1;
                    if (frame_pos == lfr_pkg::POS_ROW_CMD) begin
                        b.data = lfr_pkg::ROW_CMD_BASE | {3'b000, frame_row[4:0]};
                        b.is_cmd = 1'b1;
                    end else if (frame_pos == lfr_pkg::POS_HALF_CMD) begin
                        b.data = (frame_row < 6'd32) ? lfr_pkg::HALF_CMD_UPPER
                                                     : lfr_pkg::HALF_CMD_LOWER;
                        b.is_cmd = 1'b1;
                    end else begin
                        addr = (int'(frame_row) * STORE_STRIDE + int'(frame_pos)
                                - int'(lfr_pkg::POS_DATA0)) % STORE_DEPTH;
                        b.data = shadow_store[addr];
                        b.is_cmd = 1'b0;
                    end
                    // Step to the next byte; the last data byte of the last row ends it.
                    if (int'(frame_pos) >= BPR + 1) begin
                        frame_pos = lfr_pkg::POS_ROW_CMD;
                        if (int'(frame_row) + 1 >= ROWS) begin
                            b.last = 1'b1;
                            refresh_on = 1'b0;
                            frame_row = '0;
                        end else begin
                            frame_row = frame_row + 6'd1;
                        end
                    end else begin
                        frame_pos = frame_pos + 5'd1;
                    end
                end
            end
        endcase
    endtask

    // Offer one item, wait for it to be taken, then record what it should emit.
    task automatic send_item(input lfr_pkg::cmd_t cmd, input logic [6:0] x,
                             input logic [5:0] y, input logic v, input bit typed,
                             input lcd_byte_t typed_byte);
        int gap;
        bit emitted;
        lcd_byte_t b;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, v, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_lcd_item(cmd, x, y, v, emitted, b);
        if (emitted) pending_bytes.push_back(typed ? typed_byte : b);
        if (cmd == lfr_pkg::CMD_CLEAR) clears_sent++;
        if (cmd != lfr_pkg::CMD_TICK || emitted) items_done++;
    endtask

    task automatic send_plain(input lfr_pkg::cmd_t cmd, input logic [6:0] x,
                              input logic [5:0] y, input logic v);
        send_item(cmd, x, y, v, 1'b0, '0);
    endtask

    task automatic send_random_pixel();
        send_plain(lfr_pkg::CMD_WRITE_PIXEL, 7'($urandom_range(0, 127)),
                   6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    endtask

    // Any item at all, with clears kept rare since each one walks the whole store.
    task automatic send_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) send_random_pixel();
        else if (r < 43)
            send_plain(lfr_pkg::CMD_CLEAR, 7'($urandom), 6'($urandom), 1'($urandom));
        else if (r < 55)
            send_plain(lfr_pkg::CMD_START, 7'($urandom), 6'($urandom), 1'($urandom));
        else send_plain(lfr_pkg::CMD_TICK, 7'($urandom), 6'($urandom), 1'($urandom));
    endtask

    // A start followed by a run of ticks, with pixel writes and now and then a clear mixed in.
    task automatic refresh_burst(input int ticks, input int write_pct);
        int r;
        send_plain(lfr_pkg::CMD_START, 7'($urandom), 6'($urandom), 1'($urandom));
        for (int i = 0; i < ticks; i++) begin
            r = $urandom_range(0, 999);
            if (r < write_pct * 10) send_random_pixel();
            else if (r < write_pct * 10 + 5)
                send_plain(lfr_pkg::CMD_CLEAR, 7'($urandom), 6'($urandom), 1'($urandom));
            send_plain(lfr_pkg::CMD_TICK, 7'($urandom), 6'($urandom), 1'($urandom));
        end
    endtask

    // Hold the input until every expected byte has come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_bytes.size() != 0) @(posedge aclk);
    endtask

    // Result side: check accepted bytes and stall at random.
    initial begin
        int stall;
        lcd_byte_t want;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_bytes.size() == 0) begin
                    errors++;
                    $display("%0t: expected no byte, got %02h cmd %0b last %0b", $time,
                             m_tdata, m_tuser[0], m_tlast);
                end else begin
                    want = pending_bytes.pop_front();
                    bytes_checked++;
                    if (m_tlast === 1'b1) frames_seen++;
                    if (m_tdata !== want.data || m_tuser[0] !== want.is_cmd
                        || m_tlast !== want.last) begin
                        errors++;
                        $display({"%0t: expected byte %02h cmd %0b last %0b,",
                                  " got %02h cmd %0b last %0b"},
                                 $time, want.data, want.is_cmd, want.last,
                                 m_tdata, m_tuser[0], m_tlast);
                    end
                end
            end
            if (calm) begin
                stall = 0;
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_tready <= (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    // Stimulus: reset, directed table, one full frame, then random bursts and noise.
    initial begin
        lcd_byte_t tb;
        int random_goal;
        for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = 8'h00;
        frame_row = '0;
        frame_pos = lfr_pkg::POS_ROW_CMD;
        refresh_on = 1'b0;

        directed = '{
            // Tick while idle emits nothing.
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_START,       7'd0,   6'd0,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, 8'h80, 1'b1, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, 8'h80, 1'b1, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
            // Writes during a refresh show up in bytes sent later.
            '{lfr_pkg::CMD_WRITE_PIXEL, 7'd0,   6'd0,  1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_WRITE_PIXEL, 7'd127, 6'd63, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_WRITE_PIXEL, 7'd9,   6'd0,  1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, 8'h40, 1'b0, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            // Start during a refresh goes back to row 0.
            '{lfr_pkg::CMD_START,       7'd127, 6'd63, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd127, 6'd63, 1'b1, 1'b1, 8'h80, 1'b1, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, 8'h80, 1'b1, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, 8'h80, 1'b0, 1'b0},
            '{lfr_pkg::CMD_WRITE_PIXEL, 7'd7,   6'd0,  1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_WRITE_PIXEL, 7'd0,   6'd0,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            // Clear during a refresh empties the rest of the frame.
            '{lfr_pkg::CMD_CLEAR,       7'd127, 6'd63, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_WRITE_PIXEL, 7'd0,   6'd63, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_WRITE_PIXEL, 7'd127, 6'd0,  1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{lfr_pkg::CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            tb = '{directed[i].want_data, directed[i].want_cmd, directed[i].want_last};
            send_item(directed[i].cmd, directed[i].x, directed[i].y, directed[i].v,
                      directed[i].typed, tb);
        end
        wait_for_drain();

        // One whole frame with idling on both sides, so the marked last byte is seen.
        calm = 1'b0;
        refresh_burst(FRAME_BYTES, 3);
        wait_for_drain();

        // Random part: mostly short refresh bursts with random content, some noise.
        random_goal = items_done + RANDOM_ITEMS;
        while (items_done < random_goal) begin
            calm = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) < 7) refresh_burst($urandom_range(1, 60), 30);
            else repeat ($urandom_range(1, 12)) send_random_item();
            if ($urandom_range(0, 19) == 0) wait_for_drain();
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d items including %0d store clears.", items_done, clears_sent);
        $display("Checked %0d display bytes across %0d completed frames.",
                 bytes_checked, frames_seen);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
